// ===== rtl/gclp_pkg.sv =====
package gclp_pkg;

    // Field widths
    localparam int CHAR_BITS          = 8;
    localparam int LETTERS            = 26;
    localparam int LETTER_BITS        = 5;
    localparam int OUT_INT_BITS       = 32;
    localparam int OUT_FRAC_BITS      = 32;
    localparam int EXP_BITS           = 8;
    localparam int VALUE_BITS_DEFAULT = 32;

    typedef logic [CHAR_BITS-1:0]   t_char;
    typedef logic [LETTER_BITS-1:0] t_letter;
    typedef logic [EXP_BITS-1:0]    t_exp;

    // Character codes
    localparam t_char CH_NUL     = 8'h00;
    localparam t_char CH_LF      = 8'h0A;
    localparam t_char CH_CR      = 8'h0D;
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_POINT   = 8'h2E;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_NINE    = 8'h39;
    localparam t_char CH_SEMI    = 8'h3B;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7A;
    localparam t_char CASE_SHIFT = 8'h20;

    localparam t_letter LAST_LETTER = t_letter'(LETTERS - 1);
    localparam t_exp    EXP_FLOOR   = 8'h80;

    typedef enum logic [1:0] {
        PH_EOL,
        PH_NAME,
        PH_VALUE,
        PH_COMMENT
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_PARSE,
        SEQ_SCAN,
        SEQ_WAIT
    } t_seq;

endpackage

// ===== rtl/gclp_if.sv =====
interface gclp_char_if;
    logic              valid;
    logic              ready;
    gclp_pkg::t_char   character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface gclp_field_if;
    logic                                  valid;
    logic                                  ready;
    gclp_pkg::t_letter                     letter_index;
    logic signed [gclp_pkg::OUT_INT_BITS-1:0] integer_part;
    logic [gclp_pkg::OUT_FRAC_BITS-1:0]    fraction_digits;
    logic signed [gclp_pkg::EXP_BITS-1:0]  decimal_exponent;
    logic                                  last_field;

    modport source (output valid, output letter_index, output integer_part,
                    output fraction_digits, output decimal_exponent, output last_field,
                    input ready);
    modport sink   (input valid, input letter_index, input integer_part,
                    input fraction_digits, input decimal_exponent, input last_field,
                    output ready);
endinterface

// ===== rtl/gclp_ram.sv =====
module gclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/gcode_line_parser_core.sv =====
// Channel   Dir  Payload                                                   Transfer
// i_char    in   character                                                 valid & ready
// o_field   out  letter_index, integer_part, fraction_digits,              valid & ready
//                decimal_exponent, last_field
//
// Flow: one character per cycle while parsing. An end-of-line character that
// closes a line with stored fields starts an emit pass. The pass walks the flag
// register from A up to the highest set letter, one letter a cycle, but each set
// letter adds a wait state for the registered read of the field RAM, held longer
// if the output side stalls. i_char.ready is low for the whole pass.
// Reset: synchronous, active low; clears phase, flags and handshake state. The
// field RAM has no reset: an entry is read only after its flag has been set.
// Stalls: the output register lets the parser take new characters while the
// last field of a line still waits to be taken.
module gcode_line_parser_core #(
    parameter int VALUE_BITS = gclp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gclp_char_if.sink     i_char,
    gclp_field_if.source  o_field
);

    // RAM entry: {integer (sign applied), fraction digits, exponent}
    localparam int RAM_W = 2 * VALUE_BITS + gclp_pkg::EXP_BITS;

    // Parser state
    gclp_pkg::t_phase          r_phase, n_phase;
    logic                      r_line_valid, n_line_valid;
    gclp_pkg::t_letter         r_letter, n_letter;
    logic [VALUE_BITS-1:0]     r_int_acc, n_int_acc;
    logic [VALUE_BITS-1:0]     r_frac_acc, n_frac_acc;
    gclp_pkg::t_exp            r_exp, n_exp;
    logic                      r_neg, n_neg;
    logic                      r_point, n_point;
    logic [gclp_pkg::LETTERS-1:0] r_flags, n_flags;

    // Emit sequencer
    gclp_pkg::t_seq            r_seq, n_seq;
    gclp_pkg::t_letter         r_idx, n_idx;

    // Output register
    logic                      r_out_valid;
    gclp_pkg::t_letter         r_out_letter;
    logic signed [gclp_pkg::OUT_INT_BITS-1:0] r_out_int;
    logic [gclp_pkg::OUT_FRAC_BITS-1:0]       r_out_frac;
    gclp_pkg::t_exp            r_out_exp;
    logic                      r_out_last;

    // RAM ports
    logic                      ram_wr_en;
    gclp_pkg::t_letter         ram_wr_addr;
    logic [RAM_W-1:0]          ram_wr_data;
    logic                      ram_rd_en;
    logic [RAM_W-1:0]          ram_rd_data;

    logic                      in_fire;
    logic                      load_out;
    logic                      higher_set;
    logic                      do_store;
    logic                      is_eol;
    gclp_pkg::t_char           upper;
    logic [VALUE_BITS-1:0]     signed_int;

    gclp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (gclp_pkg::LETTERS)
    ) u_field_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    assign i_char.ready = (r_seq == gclp_pkg::SEQ_PARSE);
    assign in_fire      = i_char.valid && i_char.ready;

    // Any set letter above the one being emitted; none means this is the last
    always_comb begin
        higher_set = 1'b0;
        for (int j = 0; j < gclp_pkg::LETTERS; j++) begin
            if (gclp_pkg::t_letter'(j) > r_idx) begin
                higher_set = higher_set | r_flags[j];
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_line_valid = r_line_valid;
        n_letter     = r_letter;
        n_int_acc    = r_int_acc;
        n_frac_acc   = r_frac_acc;
        n_exp        = r_exp;
        n_neg        = r_neg;
        n_point      = r_point;
        n_flags      = r_flags;
        n_seq        = r_seq;
        n_idx        = r_idx;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_letter;
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        load_out     = 1'b0;
        do_store     = 1'b0;
        signed_int   = '0;

        upper = i_char.character;
        if (i_char.character inside {[gclp_pkg::CH_LOWER_A:gclp_pkg::CH_LOWER_Z]}) begin
            upper = i_char.character - gclp_pkg::CASE_SHIFT;
        end
        is_eol = (i_char.character == gclp_pkg::CH_NUL) ||
                 (i_char.character == gclp_pkg::CH_LF)  ||
                 (i_char.character == gclp_pkg::CH_CR);

        if (in_fire) begin
            // First character after end of line opens a fresh line
            if (r_phase == gclp_pkg::PH_EOL) begin
                n_phase      = gclp_pkg::PH_NAME;
                n_line_valid = 1'b0;
                n_letter     = '0;
                n_int_acc    = '0;
                n_frac_acc   = '0;
                n_exp        = '0;
                n_neg        = 1'b0;
                n_point      = 1'b0;
                n_flags      = '0;
            end

            if (i_char.character == gclp_pkg::CH_SEMI) begin
                n_phase = gclp_pkg::PH_COMMENT;
            end else if (is_eol) begin
                do_store = (n_phase == gclp_pkg::PH_VALUE);
            end else begin
                case (n_phase)
                    gclp_pkg::PH_NAME: begin
                        if (i_char.character != gclp_pkg::CH_SPACE) begin
                            if (upper inside {[gclp_pkg::CH_UPPER_A:gclp_pkg::CH_UPPER_Z]}) begin
                                n_phase  = gclp_pkg::PH_VALUE;
                                n_letter = gclp_pkg::t_letter'(upper - gclp_pkg::CH_UPPER_A);
                            end else begin
                                // bad character: drop the line
                                n_phase      = gclp_pkg::PH_COMMENT;
                                n_line_valid = 1'b0;
                                n_flags      = '0;
                                n_letter     = '0;
                                n_int_acc    = '0;
                                n_frac_acc   = '0;
                                n_exp        = '0;
                                n_neg        = 1'b0;
                                n_point      = 1'b0;
                            end
                        end
                    end
                    gclp_pkg::PH_VALUE: begin
                        if (i_char.character == gclp_pkg::CH_MINUS) begin
                            n_neg = 1'b1;
                        end else if (i_char.character inside
                                     {[gclp_pkg::CH_ZERO:gclp_pkg::CH_NINE]}) begin
                            // x*10 + d as two shifts and adds
                            if (!n_point) begin
                                n_int_acc = (n_int_acc << 3) + (n_int_acc << 1) +
                                    VALUE_BITS'(i_char.character - gclp_pkg::CH_ZERO);
                            end else begin
                                n_frac_acc = (n_frac_acc << 3) + (n_frac_acc << 1) +
                                    VALUE_BITS'(i_char.character - gclp_pkg::CH_ZERO);
                                if (n_exp != gclp_pkg::EXP_FLOOR) begin
                                    n_exp = n_exp - gclp_pkg::t_exp'(1);
                                end
                            end
                        end else if (i_char.character == gclp_pkg::CH_POINT) begin
                            n_point = 1'b1;
                        end else if (i_char.character == gclp_pkg::CH_SPACE) begin
                            do_store = 1'b1;
                        end else begin
                            n_phase      = gclp_pkg::PH_COMMENT;
                            n_line_valid = 1'b0;
                            n_flags      = '0;
                            n_letter     = '0;
                            n_int_acc    = '0;
                            n_frac_acc   = '0;
                            n_exp        = '0;
                            n_neg        = 1'b0;
                            n_point      = 1'b0;
                        end
                    end
                    default: begin
                        // comment: rest of line ignored
                    end
                endcase
            end

            // Word store: one RAM write, flag set, word cleared
            if (do_store) begin
                signed_int   = n_neg ? (VALUE_BITS'(0) - n_int_acc) : n_int_acc;
                ram_wr_en    = 1'b1;
                ram_wr_addr  = n_letter;
                ram_wr_data  = {signed_int, n_frac_acc, n_exp};
                n_flags[n_letter] = 1'b1;
                n_line_valid = 1'b1;
                n_phase      = gclp_pkg::PH_NAME;
                n_letter     = '0;
                n_int_acc    = '0;
                n_frac_acc   = '0;
                n_exp        = '0;
                n_neg        = 1'b0;
                n_point      = 1'b0;
            end

            if (is_eol && (i_char.character != gclp_pkg::CH_SEMI)) begin
                n_phase = gclp_pkg::PH_EOL;
                if (n_line_valid) begin
                    n_seq = gclp_pkg::SEQ_SCAN;
                    n_idx = '0;
                end
            end
        end

        case (r_seq)
            gclp_pkg::SEQ_SCAN: begin
                if (r_flags[r_idx]) begin
                    ram_rd_en = 1'b1;
                    n_seq     = gclp_pkg::SEQ_WAIT;
                end else if (r_idx == gclp_pkg::LAST_LETTER) begin
                    n_seq = gclp_pkg::SEQ_PARSE;
                end else begin
                    n_idx = r_idx + gclp_pkg::t_letter'(1);
                end
            end
            gclp_pkg::SEQ_WAIT: begin
                if (!r_out_valid || o_field.ready) begin
                    load_out = 1'b1;
                    if (!higher_set || (r_idx == gclp_pkg::LAST_LETTER)) begin
                        n_seq = gclp_pkg::SEQ_PARSE;
                    end else begin
                        n_idx = r_idx + gclp_pkg::t_letter'(1);
                        n_seq = gclp_pkg::SEQ_SCAN;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= gclp_pkg::PH_EOL;
            r_line_valid <= 1'b0;
            r_letter     <= '0;
            r_int_acc    <= '0;
            r_frac_acc   <= '0;
            r_exp        <= '0;
            r_neg        <= 1'b0;
            r_point      <= 1'b0;
            r_flags      <= '0;
            r_seq        <= gclp_pkg::SEQ_PARSE;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_line_valid <= n_line_valid;
            r_letter     <= n_letter;
            r_int_acc    <= n_int_acc;
            r_frac_acc   <= n_frac_acc;
            r_exp        <= n_exp;
            r_neg        <= n_neg;
            r_point      <= n_point;
            r_flags      <= n_flags;
            r_seq        <= n_seq;
            r_idx        <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_field.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: integer sign-extended or cut to 32 bits
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_letter <= r_idx;
            r_out_int    <= gclp_pkg::OUT_INT_BITS'(
                            $signed(ram_rd_data[RAM_W-1 -: VALUE_BITS]));
            r_out_frac   <= gclp_pkg::OUT_FRAC_BITS'(
                            ram_rd_data[gclp_pkg::EXP_BITS +: VALUE_BITS]);
            r_out_exp    <= ram_rd_data[gclp_pkg::EXP_BITS-1:0];
            r_out_last   <= !higher_set;
        end
    end

    assign o_field.valid            = r_out_valid;
    assign o_field.letter_index     = r_out_letter;
    assign o_field.integer_part     = r_out_int;
    assign o_field.fraction_digits  = r_out_frac;
    assign o_field.decimal_exponent = r_out_exp;
    assign o_field.last_field       = r_out_last;

    // RAM write and read never coincide: no read while a word is stored
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("field RAM written and read in the same cycle");

    // Line holds fields exactly when some letter flag is set
    a_line_valid_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_valid == (r_flags != '0))
        else $error("line_valid disagrees with letter flags");

    // Only set letters are emitted
    a_emit_set_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> r_flags[r_idx])
        else $error("emitting a letter whose flag is clear");

    // An end of line with stored fields starts the emit pass
    a_eol_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_eol && n_line_valid) |=> (r_seq == gclp_pkg::SEQ_SCAN))
        else $error("emit pass not started after end of line");

    // Flags stay put while they are being walked
    a_flags_stable_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != gclp_pkg::SEQ_PARSE) |=> $stable(r_flags))
        else $error("letter flags changed during emit pass");

endmodule

// ===== tb/sv/gcode_line_parser_core_test.sv =====
`timescale 1ns / 1ps

module gcode_line_parser_core_test;
    import gclp_pkg::*;

    // Accumulator width under test; the predictor follows the same width.
    localparam int VB        = VALUE_BITS_DEFAULT;
    // Watchdog in clock cycles. The slowest legal run stays under this:
    // ~1500 characters each behind the longest sender gap, plus every emitted
    // field held up by the longest receiver stall.
    localparam int LIMIT     = 1000000;
    localparam int RAND_CHARS = 200;
    localparam int MAX_PRINTS = 40;

    // One emitted field as seen on the output channel.
    typedef struct {
        t_letter                         letter;
        logic signed [OUT_INT_BITS-1:0]  int_part;
        logic [OUT_FRAC_BITS-1:0]        frac;
        logic signed [EXP_BITS-1:0]      expo;
        logic                            last;
    } t_field;

    // Directed line: text, terminator, and either a typed expectation
    // (typed = 0 or 1 fields) or typed = -1 to leave it to the predictor.
    typedef struct {
        string   text;
        t_char   eol;
        int      typed;
        t_field  want;
    } t_line_row;

    logic clk = 1'b0;
    logic rst_n;

    gclp_char_if  char_if();
    gclp_field_if field_if();

    gcode_line_parser_core #(.VALUE_BITS(VB)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_if),
        .o_field (field_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor: own copy of the parser state
    // ------------------------------------------------------------------
    t_phase           ph        = PH_EOL;
    bit               line_ok   = 1'b0;
    t_letter          cur       = '0;
    logic [VB-1:0]    int_acc   = '0;
    logic [VB-1:0]    frac_acc  = '0;
    t_exp             exp_cnt   = '0;
    bit               neg       = 1'b0;
    bit               point     = 1'b0;
    bit               set_flags [LETTERS];
    logic [VB-1:0]    int_tab   [LETTERS];
    logic [VB-1:0]    frac_tab  [LETTERS];
    t_exp             exp_tab   [LETTERS];

    t_field  pending_fields[$];   // fields still owed by the block, oldest first
    bit      predict_quiet = 1'b0; // set while a directed line carries a typed expectation
    int      mismatch_count = 0;
    int      clk_count = 0;

    initial foreach (set_flags[k]) set_flags[k] = 1'b0;

    task automatic clear_word();
        ph       = PH_NAME;
        cur      = '0;
        int_acc  = '0;
        frac_acc = '0;
        exp_cnt  = '0;
        neg      = 1'b0;
        point    = 1'b0;
    endtask

    task automatic clear_line();
        clear_word();
        foreach (set_flags[k]) set_flags[k] = 1'b0;
        line_ok = 1'b0;
    endtask

    // Commit the word in progress under its letter; only a word in the value phase counts.
    task automatic store_word();
        if (ph != PH_VALUE) return;
        int_tab[cur]   = neg ? (~int_acc + 1'b1) : int_acc;
        frac_tab[cur]  = frac_acc;
        exp_tab[cur]   = exp_cnt;
        set_flags[cur] = 1'b1;
        clear_word();
        line_ok = 1'b1;
    endtask

    // Advance the predictor by one accepted character; at end of line queue the fields.
    task automatic apply_char(input t_char c);
        t_char                u;
        t_field               f;
        t_field               line_out[$];
        logic signed [VB-1:0] sv;

        if (ph == PH_EOL) clear_line();

        if (c == CH_SEMI) begin
            // comment: the unfinished word is lost, earlier words survive
            ph = PH_COMMENT;
            return;
        end

        if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
            store_word();
            ph = PH_EOL;
            if (!line_ok) return;
            for (int k = 0; k < LETTERS; k++) begin
                if (set_flags[k]) begin
                    sv         = int_tab[k];
                    f.letter   = t_letter'(k);
                    f.int_part = sv;           // sign-extend or truncate to 32 bits
                    f.frac     = OUT_FRAC_BITS'(frac_tab[k]);
                    f.expo     = exp_tab[k];
                    f.last     = 1'b0;
                    line_out.push_back(f);
                end
            end
            line_out[line_out.size()-1].last = 1'b1;
            if (!predict_quiet)
                foreach (line_out[k]) pending_fields.push_back(line_out[k]);
            return;
        end

        case (ph)
            PH_NAME: begin
                if (c == CH_SPACE) return;
                u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? t_char'(c - CASE_SHIFT) : c;
                if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
                    ph  = PH_VALUE;
                    cur = t_letter'(u - CH_UPPER_A);
                end else begin
                    clear_line();
                    ph = PH_COMMENT;
                end
            end
            PH_VALUE: begin
                if (c == CH_MINUS) begin
                    neg = 1'b1;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (!point) begin
                        int_acc = int_acc * 10 + VB'(c - CH_ZERO);
                    end else begin
                        frac_acc = frac_acc * 10 + VB'(c - CH_ZERO);
                        if (exp_cnt != EXP_FLOOR) exp_cnt = exp_cnt - 1'b1;
                    end
                end else if (c == CH_POINT) begin
                    point = 1'b1;
                end else if (c == CH_SPACE) begin
                    store_word();
                end else begin
                    // stray byte kills the whole line
                    clear_line();
                    ph = PH_COMMENT;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: checking and receiver stalls
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch %0s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Each output transfer is compared with the oldest owed field.
    always @(posedge clk) begin : check_fields
        t_field want;
        if (rst_n === 1'b1 && field_if.valid === 1'b1 && field_if.ready === 1'b1) begin
            if (pending_fields.size() == 0) begin
                flag_mismatch("field with none owed, letter", field_if.letter_index, -1);
            end else begin
                want = pending_fields.pop_front();
                if (field_if.letter_index !== want.letter)
                    flag_mismatch("letter_index", field_if.letter_index, want.letter);
                if (field_if.integer_part !== want.int_part)
                    flag_mismatch("integer_part", field_if.integer_part, want.int_part);
                if (field_if.fraction_digits !== want.frac)
                    flag_mismatch("fraction_digits", field_if.fraction_digits, want.frac);
                if (field_if.decimal_exponent !== want.expo)
                    flag_mismatch("decimal_exponent", field_if.decimal_exponent, want.expo);
                if (field_if.last_field !== want.last)
                    flag_mismatch("last_field", field_if.last_field, want.last);
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    int rx_hold = 0;
    bit rx_calm = 1'b0;

    // Receiver back-pressure, with calm stretches where ready stays high.
    always @(posedge clk) begin
        if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
        if (rx_hold > 0) begin
            field_if.ready <= 1'b0;
            rx_hold--;
        end else begin
            field_if.ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
        end
    end

    always @(posedge clk) begin
        clk_count++;
        if (clk_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    bit    tx_calm = 1'b0;
    t_char line_buf[$];
    t_line_row directed_lines[$];

    // One character transfer: optional gap, then hold valid until ready.
    task automatic send_char(input t_char c);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.character <= c;
        do @(posedge clk); while (char_if.ready !== 1'b1);
        apply_char(c);
    endtask

    // Hold off until the block has delivered every owed field.
    task automatic drain_fields();
        char_if.valid <= 1'b0;
        wait (pending_fields.size() == 0);
        @(posedge clk);
    endtask

    task automatic add_line(input string text, input t_char eol, input int typed,
                            input t_field want);
        t_line_row r;
        r.text  = text;
        r.eol   = eol;
        r.typed = typed;
        r.want  = want;
        directed_lines.push_back(r);
    endtask

    // Random line: mostly well-formed words with random content, some noise,
    // some stray bytes and comments.
    task automatic build_random_line();
        int    kind;
        int    nd;
        t_char word_q[$];
        t_char c;

        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) line_buf.push_back(t_char'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
            for (int w = $urandom_range(1, 6); w > 0; w--) begin
                c = t_char'(CH_UPPER_A + $urandom_range(0, 25));
                if ($urandom_range(0, 1)) c = t_char'(c + CASE_SHIFT);
                line_buf.push_back(c);
                word_q.delete();
                // occasional long integers to force wrap-around
                nd = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
                repeat (nd) word_q.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 1)) begin
                    word_q.push_back(CH_POINT);
                    // rare very long fraction runs the exponent into its floor
                    nd = ($urandom_range(0, 49) == 0) ? 140 : $urandom_range(0, 8);
                    repeat (nd) word_q.push_back(t_char'(CH_ZERO + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 3) == 0)
                    word_q.insert($urandom_range(0, word_q.size()), CH_MINUS);
                foreach (word_q[k]) line_buf.push_back(word_q[k]);
                if (w > 1) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
            end
            if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
            if (kind < 18) begin
                line_buf.insert($urandom_range(0, line_buf.size()),
                                t_char'($urandom_range(0, 255)));
            end else if (kind < 30) begin
                line_buf.push_back(CH_SEMI);
                repeat ($urandom_range(0, 8))
                    line_buf.push_back(t_char'($urandom_range(CH_SPACE, 8'h7E)));
            end
        end
        case ($urandom_range(0, 2))
            0:       line_buf.push_back(CH_NUL);
            1:       line_buf.push_back(CH_LF);
            default: line_buf.push_back(CH_CR);
        endcase
    endtask

    initial begin
        t_field    none;
        string     s;
        t_line_row r;
        int        rand_sent;

        rst_n             <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.character <= CH_NUL;
        none = '{'0, '0, '0, '0, 1'b0};

        // --- directed lines ---
        // bare end of line straight after reset: nothing stored, nothing out
        add_line("", CH_LF, 0, none);
        // lower-case letter with no digits: empty word
        add_line("a", CH_CR, 1, '{5'd0, 32'sd0, 32'd0, 8'sd0, 1'b1});
        // most negative integer, via wrap and negate
        add_line("Z-2147483648", CH_LF, 1, '{5'd25, 32'sh8000_0000, 32'd0, 8'sd0, 1'b1});
        // all-ones integer reads back as -1, one fraction digit, NUL end
        add_line("x4294967295.9", CH_NUL, 1, '{5'd23, -32'sd1, 32'd9, -8'sd1, 1'b1});
        // stray byte in the name phase, at line start and after a stored word
        add_line("5", CH_LF, 0, none);
        add_line("A1 ?", CH_LF, 0, none);
        add_line("T1 ~ U2", CH_CR, 0, none);
        // comment drops the unfinished word but keeps earlier ones
        add_line("P5;Q6", CH_CR, 0, none);
        add_line("M7 ;N8", CH_CR, -1, none);
        // repeated letter overwrites; output in letter order
        add_line("G1 X2 G3", CH_NUL, -1, none);
        // leading spaces, minus in odd places
        add_line("  y-1.25- k.5", CH_LF, -1, none);
        add_line("W12.3", CH_LF, -1, none);
        // second terminator in a row: start of a fresh, empty line
        add_line("", CH_CR, 0, none);
        // exponent floor and fraction wrap
        s = "f.";
        repeat (13) s = {s, "9876543210"};
        add_line(s, CH_LF, -1, none);
        // every letter set: longest emit pass
        s = "";
        for (int k = 0; k < LETTERS; k++)
            s = {s, $sformatf("%c%0d ", (k % 2) ? CH_LOWER_A + k : CH_UPPER_A + k, k)};
        add_line(s, CH_CR, -1, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_lines[i]) begin
            r = directed_lines[i];
            tx_calm = ($urandom_range(0, 2) == 0);
            if (r.typed >= 0) begin
                if (r.typed == 1) pending_fields.push_back(r.want);
                predict_quiet = 1'b1;
            end
            for (int j = 0; j < r.text.len(); j++) send_char(t_char'(r.text[j]));
            send_char(r.eol);
            predict_quiet = 1'b0;
        end

        // sender holds off until the block has caught up
        drain_fields();

        // --- random lines ---
        rand_sent = 0;
        while (rand_sent < RAND_CHARS) begin
            build_random_line();
            tx_calm = ($urandom_range(0, 4) == 0);
            foreach (line_buf[k]) send_char(line_buf[k]);
            rand_sent += line_buf.size();
            if ($urandom_range(0, 14) == 0) drain_fields();
        end

        char_if.valid <= 1'b0;
        wait (pending_fields.size() == 0);
        // room for a late emit pass to show any field nobody asked for
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
